### hw/rtl/vector_transform_4x4_macros.svh
// ----------------------------------------------------------------------------
// vector_transform_4x4 assertion macros
// Shared concurrent assertion forms, clocked on clk_i against rst_ni.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TRANSFORM_4X4_MACROS_SVH
`define VECTOR_TRANSFORM_4X4_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VT4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VT4_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/vt4_pkg.sv
// ----------------------------------------------------------------------------
// vt4_pkg
// Widths, coefficient layout, reset matrix and control types shared by the
// 4x4 vector transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

  localparam int Lanes    = 4;
  localparam int DataW    = 16;
  localparam int CfgW     = Lanes * DataW;
  localparam int IdxW     = 2;
  localparam int ProdW    = 2 * DataW;
  localparam int AccW     = ProdW + 2;
  localparam int FracBits = 8;

  // Register indexes of the matrix rows.
  typedef enum logic [IdxW-1:0] {
    RegRow0 = 2'd0,
    RegRow1 = 2'd1,
    RegRow2 = 2'd2,
    RegRow3 = 2'd3
  } cfg_idx_e;

  // Identity matrix, Q8.8 one on the diagonal.
  localparam logic [CfgW-1:0] RowRst [Lanes] = '{
    64'h0000_0000_0000_0100,
    64'h0000_0000_0100_0000,
    64'h0000_0100_0000_0000,
    64'h0100_0000_0000_0000
  };

  localparam logic signed [DataW-1:0] LaneMax = 16'sh7FFF;
  localparam logic signed [DataW-1:0] LaneMin = 16'sh8000;

  // Stage load enables handed from the pipeline control to the lanes.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } vt4_ctrl_t;

endpackage

### hw/rtl/vt4_lane.sv
// ----------------------------------------------------------------------------
// vt4_lane
// One matrix row dotted with the input vector: products, sum with rounding
// bias, then floor shift and clamp to 16 bits.
// ----------------------------------------------------------------------------
module vt4_lane (
  input  logic                                  clk_i,
  input  vt4_pkg::vt4_ctrl_t                    ctrl_i,
  input  logic [vt4_pkg::CfgW-1:0]              row_i,
  input  logic signed [vt4_pkg::DataW-1:0]      vec_i [vt4_pkg::Lanes],
  output logic signed [vt4_pkg::DataW-1:0]      res_o,
  output logic                                  sat_o
);

  localparam int AccW  = vt4_pkg::AccW;
  localparam int DataW = vt4_pkg::DataW;
  localparam int ProdW = vt4_pkg::ProdW;

  localparam logic signed [AccW-1:0] Half  = AccW'((1 << vt4_pkg::FracBits) >> 1);
  localparam logic signed [AccW-1:0] AccMax = AccW'(vt4_pkg::LaneMax);
  localparam logic signed [AccW-1:0] AccMin = AccW'(vt4_pkg::LaneMin);

  logic signed [DataW-1:0]          coef [vt4_pkg::Lanes];
  logic signed [vt4_pkg::ProdW-1:0] prod_q [vt4_pkg::Lanes];
  logic signed [AccW-1:0]           acc_d, acc_q;
  logic signed [AccW-1:0]           shifted;
  logic signed [DataW-1:0]          res_d, res_q;
  logic                             sat_d, sat_q;

  for (genvar c = 0; c < vt4_pkg::Lanes; c++) begin : g_coef
    assign coef[c] = row_i[c*DataW +: DataW];
  end

  // Stage 1: one multiplier per column.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      for (int c = 0; c < vt4_pkg::Lanes; c++) begin
        prod_q[c] <= ProdW'(coef[c]) * ProdW'(vec_i[c]);
      end
    end
  end

  // Stage 2: exact sum plus rounding bias.
  assign acc_d = AccW'(prod_q[0]) + AccW'(prod_q[1]) + AccW'(prod_q[2])
               + AccW'(prod_q[3]) + Half;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_en) begin
      acc_q <= acc_d;
    end
  end

  // Stage 3: floor shift and clamp.
  always_comb begin
    shifted = acc_q >>> vt4_pkg::FracBits;
    sat_d   = 1'b1;
    if (shifted > AccMax) begin
      res_d = vt4_pkg::LaneMax;
    end else if (shifted < AccMin) begin
      res_d = vt4_pkg::LaneMin;
    end else begin
      res_d = shifted[DataW-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s3_en) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

### hw/rtl/vt4_merge.sv
// ----------------------------------------------------------------------------
// vt4_merge
// Output register: collect the four lane results and fold their clamp flags.
// ----------------------------------------------------------------------------
module vt4_merge (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic signed [vt4_pkg::DataW-1:0]  res_i [vt4_pkg::Lanes],
  input  logic [vt4_pkg::Lanes-1:0]         sat_i,
  output logic signed [vt4_pkg::DataW-1:0]  res_o [vt4_pkg::Lanes],
  output logic                              sat_o
);

  logic signed [vt4_pkg::DataW-1:0] res_q [vt4_pkg::Lanes];
  logic                             sat_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int r = 0; r < vt4_pkg::Lanes; r++) begin
        res_q[r] <= res_i[r];
      end
      sat_q <= |sat_i;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

### hw/rtl/vector_transform_4x4.sv
// ----------------------------------------------------------------------------
// vector_transform_4x4
// 4x4 signed Q8.8 matrix times a stream of 4-element Q8.8 vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Write the four matrix rows through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no request is in flight; each row packs four Q8.8 coefficients, column 0
//   in the low bits. Reset loads the identity matrix and empties the pipeline.
//   A request (in_x_i..in_w_i) is taken when in_valid_i and in_ready_o are
//   both high; its result (out_x_o..out_w_o, saturated_o) is offered on
//   out_valid_o and leaves when out_ready_i is high.
//   From accept to out_valid_o, the accepting edge loads the products, then
//   the sum with bias and then the shift and clamp are registered in each of
//   four row lanes, then the merging output register. Throughput is one
//   request per cycle while the receiver keeps up, set by the 16 multipliers
//   that run in parallel with one register stage per step.
//   Each stage moves forward whenever the stage after it is empty or moving,
//   so bubbles close up. When the receiver stalls, the output register holds
//   its result and up to three more requests are still taken before
//   in_ready_o drops. saturated_o is set when any lane clamped.
// ----------------------------------------------------------------------------
`include "vector_transform_4x4_macros.svh"

module vector_transform_4x4 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [vt4_pkg::IdxW-1:0]          cfg_idx_i,
  input  logic [vt4_pkg::CfgW-1:0]          cfg_data_i,
  // Input vector channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [vt4_pkg::DataW-1:0]  in_x_i,
  input  logic signed [vt4_pkg::DataW-1:0]  in_y_i,
  input  logic signed [vt4_pkg::DataW-1:0]  in_z_i,
  input  logic signed [vt4_pkg::DataW-1:0]  in_w_i,
  // Result vector channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [vt4_pkg::DataW-1:0]  out_x_o,
  output logic signed [vt4_pkg::DataW-1:0]  out_y_o,
  output logic signed [vt4_pkg::DataW-1:0]  out_z_o,
  output logic signed [vt4_pkg::DataW-1:0]  out_w_o,
  output logic                              saturated_o
);

  localparam int Lanes = vt4_pkg::Lanes;

  // Matrix rows
  logic [vt4_pkg::CfgW-1:0] row_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Lanes; r++) begin
        row_q[r] <= vt4_pkg::RowRst[r];
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vt4_pkg::RegRow0: row_q[0] <= cfg_data_i;
        vt4_pkg::RegRow1: row_q[1] <= cfg_data_i;
        vt4_pkg::RegRow2: row_q[2] <= cfg_data_i;
        vt4_pkg::RegRow3: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline occupancy: stage 1..3 in the lanes, then the output register.
  logic v1_d, v1_q, v2_d, v2_q, v3_d, v3_q, ov_d, ov_q;
  logic out_free, free3, free2, free1;
  logic adv1, adv2, adv3, in_acc;
  vt4_pkg::vt4_ctrl_t ctrl;

  // Each stage may load when it is empty or its contents move on.
  assign out_free = !ov_q || out_ready_i;
  assign adv3     = v3_q && out_free;
  assign free3    = !v3_q || out_free;
  assign adv2     = v2_q && free3;
  assign free2    = !v2_q || free3;
  assign adv1     = v1_q && free2;
  assign free1    = !v1_q || free2;

  assign in_ready_o = free1;
  assign in_acc     = in_valid_i && free1;

  assign v1_d = in_acc || (v1_q && !adv1);
  assign v2_d = adv1   || (v2_q && !adv2);
  assign v3_d = adv2   || (v3_q && !adv3);
  assign ov_d = adv3   || (ov_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      ov_q <= ov_d;
    end
  end

  assign ctrl.s1_en = in_acc;
  assign ctrl.s2_en = adv1;
  assign ctrl.s3_en = adv2;

  // Row lanes
  logic signed [vt4_pkg::DataW-1:0] in_vec [Lanes];
  logic signed [vt4_pkg::DataW-1:0] lane_res [Lanes];
  logic signed [vt4_pkg::DataW-1:0] out_vec [Lanes];
  logic [Lanes-1:0]                 lane_sat;

  assign in_vec[0] = in_x_i;
  assign in_vec[1] = in_y_i;
  assign in_vec[2] = in_z_i;
  assign in_vec[3] = in_w_i;

  for (genvar r = 0; r < Lanes; r++) begin : g_lane
    vt4_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .row_i  (row_q[r]),
      .vec_i  (in_vec),
      .res_o  (lane_res[r]),
      .sat_o  (lane_sat[r])
    );
  end

  // Merge lane results into the output register.
  vt4_merge u_merge (
    .clk_i  (clk_i),
    .load_i (adv3),
    .res_i  (lane_res),
    .sat_i  (lane_sat),
    .res_o  (out_vec),
    .sat_o  (saturated_o)
  );

  assign out_valid_o = ov_q;
  assign out_x_o     = out_vec[0];
  assign out_y_o     = out_vec[1];
  assign out_z_o     = out_vec[2];
  assign out_w_o     = out_vec[3];

  // Terms for the checks below.
  logic all_full_stall, out_drain, lane_at_bound;

  assign all_full_stall = v1_q && v2_q && v3_q && ov_q && !out_ready_i;
  assign out_drain      = ov_q && out_ready_i && !adv3;
  assign lane_at_bound  = (out_x_o == vt4_pkg::LaneMax) || (out_x_o == vt4_pkg::LaneMin)
                       || (out_y_o == vt4_pkg::LaneMax) || (out_y_o == vt4_pkg::LaneMin)
                       || (out_z_o == vt4_pkg::LaneMax) || (out_z_o == vt4_pkg::LaneMin)
                       || (out_w_o == vt4_pkg::LaneMax) || (out_w_o == vt4_pkg::LaneMin);

  // Input stalls only when every stage is full behind a stalled receiver.
  `VT4_ASSERT(a_stall_full, !in_ready_o |-> all_full_stall, "input stalled with a free stage")

  // A taken result with nothing behind it empties the output register.
  `VT4_ASSERT(a_out_drain, out_drain |=> !ov_q, "output valid held after drain")

  // A clamp flag goes with at least one lane at a bound.
  `VT4_ASSERT(a_sat_bound, (out_valid_o && saturated_o) |-> lane_at_bound, "saturated set with no lane at a bound")

endmodule

### sim/tb_vector_transform_4x4.sv
// ----------------------------------------------------------------------------
// tb_vector_transform_4x4
// Self-checking bench for the 4x4 Q8.8 matrix-vector transform. A directed
// table covers identity, rounding ties and saturation at both bounds. Random
// phases then load new matrices and stream vectors with bursty requests and
// a stalling receiver. Every result is compared against its typed result or a local transform.
// ----------------------------------------------------------------------------
module tb_vector_transform_4x4;

  import vt4_pkg::*;

  // Four 16-bit lanes, index 0 is x. A matrix is four 64-bit rows, index 0 is row 0.
  typedef logic [Lanes-1:0][DataW-1:0] quad_t;
  typedef logic [Lanes-1:0][CfgW-1:0]  mat_t;

  typedef struct packed {
    quad_t lanes;
    logic  sat;
  } xform_res_t;

  // One directed request: matrix to use, input lanes and, where it is plain
  // to see, the result typed in. Rows with typed == 0 go to the predictor.
  typedef struct packed {
    logic [2:0]       mat;
    logic [DataW-1:0] x, y, z, w;
    logic             typed;
    logic [DataW-1:0] ex, ey, ez, ew;
    logic             esat;
  } dir_row_t;

  localparam int PipeLatency = 4;
  localparam int CycleLimit  = 400000;
  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 135;
  localparam int NumDirMats  = 5;
  localparam int NumDirRows  = 21;

  localparam logic signed [39:0] RoundHalf =
      (FracBits > 0) ? (40'sd1 <<< (FracBits - 1)) : 40'sd0;

  // Directed matrices, each written row 0 first.
  localparam mat_t DirMats [NumDirMats] = '{
    // identity, as after reset
    {64'h0100_0000_0000_0000, 64'h0000_0100_0000_0000,
     64'h0000_0000_0100_0000, 64'h0000_0000_0000_0100},
    // every coefficient one half: exposes rounding ties
    {64'h0080_0080_0080_0080, 64'h0080_0080_0080_0080,
     64'h0080_0080_0080_0080, 64'h0080_0080_0080_0080},
    // largest positive coefficients
    {64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
     64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF},
    // most negative coefficients
    {64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
     64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000},
    // two on the diagonal: lanes land just inside or just past the bounds
    {64'h0200_0000_0000_0000, 64'h0000_0200_0000_0000,
     64'h0000_0000_0200_0000, 64'h0000_0000_0000_0200}
  };

  localparam dir_row_t DirRows [NumDirRows] = '{
    // identity passes the vector through
    '{0, 'h0000, 'h0000, 'h0000, 'h0000, 1, 'h0000, 'h0000, 'h0000, 'h0000, 0},
    '{0, 'h7FFF, 'h8000, 'h0001, 'hFFFF, 1, 'h7FFF, 'h8000, 'h0001, 'hFFFF, 0},
    '{0, 'h8000, 'h7FFF, 'hFFFF, 'h0001, 1, 'h8000, 'h7FFF, 'hFFFF, 'h0001, 0},
    '{0, 'h5555, 'hAAAA, 'h00FF, 'hFF00, 1, 'h5555, 'hAAAA, 'h00FF, 'hFF00, 0},
    // ties go up: 0.5 -> 1, -0.5 -> 0, 1.5 -> 2, -1.5 -> -1 (in LSBs)
    '{1, 'h0001, 'h0000, 'h0000, 'h0000, 1, 'h0001, 'h0001, 'h0001, 'h0001, 0},
    '{1, 'hFFFF, 'h0000, 'h0000, 'h0000, 1, 'h0000, 'h0000, 'h0000, 'h0000, 0},
    '{1, 'h0003, 'h0000, 'h0000, 'h0000, 1, 'h0002, 'h0002, 'h0002, 'h0002, 0},
    '{1, 'hFFFD, 'h0000, 'h0000, 'h0000, 1, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0},
    '{1, 'h1234, 'h8765, 'h0F0F, 'hF0F0, 0, 'h0000, 'h0000, 'h0000, 'h0000, 0},
    // overflow on every lane, both signs
    '{2, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 1, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 1},
    '{2, 'h8000, 'h8000, 'h8000, 'h8000, 1, 'h8000, 'h8000, 'h8000, 'h8000, 1},
    '{2, 'h0000, 'h0000, 'h0000, 'h0000, 1, 'h0000, 'h0000, 'h0000, 'h0000, 0},
    '{2, 'h0001, 'h0000, 'h0000, 'h0000, 0, 'h0000, 'h0000, 'h0000, 'h0000, 0},
    '{3, 'h8000, 'h8000, 'h8000, 'h8000, 1, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 1},
    '{3, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 1, 'h8000, 'h8000, 'h8000, 'h8000, 1},
    // 1.0 * -128.0 hits the lower bound exactly; -1.0 * -128.0 is one past
    '{3, 'h0100, 'h0000, 'h0000, 'h0000, 1, 'h8000, 'h8000, 'h8000, 'h8000, 0},
    '{3, 'hFF00, 'h0000, 'h0000, 'h0000, 1, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 1},
    // doubling: only the lanes that cross a bound clamp
    '{4, 'h3FFF, 'h4000, 'hC000, 'hBFFF, 1, 'h7FFE, 'h7FFF, 'h8000, 'h8000, 1},
    '{4, 'h3FFF, 'hC000, 'h0000, 'hFFFF, 1, 'h7FFE, 'h8000, 'h0000, 'hFFFE, 0},
    '{4, 'h2AAA, 'hD555, 'h1357, 'hECA9, 0, 'h0000, 'h0000, 'h0000, 'h0000, 0},
    // identity written back through the port
    '{0, 'h0123, 'h4567, 'h89AB, 'hCDEF, 0, 'h0000, 'h0000, 'h0000, 'h0000, 0}
  };

  localparam logic [DataW-1:0] ExtremeCoefs [4] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};

  // Receiver modes: free flow, hard stall, coin-flip ready.
  typedef enum int {RxFlow, RxStall, RxChoppy} rx_mode_e;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we_i   = 1'b0;
  cfg_idx_e         cfg_idx_i  = RegRow0;
  logic [CfgW-1:0]  cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [DataW-1:0] in_x_i     = '0;
  logic [DataW-1:0] in_y_i     = '0;
  logic [DataW-1:0] in_z_i     = '0;
  logic [DataW-1:0] in_w_i     = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DataW-1:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic             saturated_o;

  // Matrix the block holds right now, kept in step with every register write.
  mat_t       matrix_rows = DirMats[0];
  xform_res_t pending_results [$];
  int         err_cnt    = 0;
  int         cycle_cnt  = 0;
  int         burst_left = 1;
  rx_mode_e   rx_mode    = RxFlow;
  int         rx_left    = 0;

  vector_transform_4x4 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .in_w_i      (in_w_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o),
    .saturated_o (saturated_o)
  );

  always #10 clk_i = ~clk_i;

  // Hard stop: far beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Row dot vector per lane: exact 34-bit sum, add half an LSB, floor-shift,
  // clamp to 16 bits. Any clamped lane raises the flag.
  function automatic xform_res_t transform_vector(input quad_t v);
    xform_res_t        res;
    logic signed [39:0] acc;
    int                r, c;
    res.sat = 1'b0;
    for (r = 0; r < Lanes; r++) begin
      acc = RoundHalf;
      for (c = 0; c < Lanes; c++)
        acc += $signed(matrix_rows[r][DataW*c +: DataW]) * $signed(v[c]);
      acc = acc >>> FracBits;
      if (acc > 40'sd32767) begin
        acc     = 40'sd32767;
        res.sat = 1'b1;
      end else if (acc < -40'sd32768) begin
        acc     = -40'sd32768;
        res.sat = 1'b1;
      end
      res.lanes[r] = acc[DataW-1:0];
    end
    return res;
  endfunction

  // Signed value of random magnitude: 1 to max_bits significant bits.
  function automatic logic [DataW-1:0] rand_q16(input int unsigned max_bits);
    int unsigned       k;
    logic signed [31:0] s;
    k = $urandom_range(max_bits, 1);
    s = $signed($urandom << (32 - k)) >>> (32 - k);
    return s[DataW-1:0];
  endfunction

  function automatic mat_t pick_matrix();
    mat_t m;
    int   r, c;
    m = DirMats[0];
    for (r = 0; r < Lanes; r++)
      for (c = 0; c < Lanes; c++)
        case ($urandom_range(4))
          0: m[r][DataW*c +: DataW] = DataW'($urandom);
          1: m[r][DataW*c +: DataW] = rand_q16(16);
          2: m[r][DataW*c +: DataW] = rand_q16(10);
          3: m[r][DataW*c +: DataW] = ExtremeCoefs[$urandom_range(3)];
          default: m[r][DataW*c +: DataW] = RowRst[r][DataW*c +: DataW];
        endcase
    return m;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Rows may only change with nothing in flight: drop the request, let the
  // pipe drain, then write all four rows back to back.
  task automatic load_matrix(input mat_t rows);
    int r;
    if (in_valid_i) in_valid_i <= 1'b0;
    wait_drained();
    repeat (PipeLatency) @(posedge clk_i);
    for (r = 0; r < Lanes; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(r);
      cfg_data_i <= rows[r];
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b0;
    matrix_rows  = rows;
  endtask

  // Offer one request, hold it until taken, record what must come back,
  // then maybe end the burst with a gap or a full drain.
  task automatic send_vector(input quad_t v, input bit typed, input xform_res_t typed_res);
    int gap;
    in_x_i     <= v[0];
    in_y_i     <= v[1];
    in_z_i     <= v[2];
    in_w_i     <= v[3];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(typed ? typed_res : transform_vector(v));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(200, 60) : $urandom_range(24, 1);
      gap        = $urandom_range(8);
      if ($urandom_range(31) == 0) begin
        // hold off until the pipe is empty
        in_valid_i <= 1'b0;
        wait_drained();
      end else if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Receiver: runs of free flow, hard stalls and coin-flip ready.
  always @(posedge clk_i) begin
    if (rx_left <= 0) begin
      case ($urandom_range(3))
        0:       begin rx_mode = RxStall;  rx_left = $urandom_range(12, 1); end
        1:       begin rx_mode = RxChoppy; rx_left = $urandom_range(40, 5); end
        default: begin rx_mode = RxFlow;   rx_left = $urandom_range(80, 10); end
      endcase
    end
    rx_left--;
    case (rx_mode)
      RxStall:  out_ready_i <= 1'b0;
      RxChoppy: out_ready_i <= 1'($urandom_range(1));
      default:  out_ready_i <= 1'b1;
    endcase
  end

  // Compare every result leaving the block with the oldest expectation.
  always @(posedge clk_i) begin
    xform_res_t want;
    quad_t      got;
    int         k;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {out_w_o, out_z_o, out_y_o, out_x_o};
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result %h sat %b with no request pending", got, saturated_o));
      end else begin
        want = pending_results.pop_front();
        for (k = 0; k < Lanes; k++)
          if (got[k] !== want.lanes[k])
            flag_error($sformatf("lane %0d got %h want %h", k, got[k], want.lanes[k]));
        if (saturated_o !== want.sat)
          flag_error($sformatf("saturated got %b want %b", saturated_o, want.sat));
      end
    end
  end

  initial begin
    int       i, ph, n, c;
    logic [2:0] cur_mat;
    quad_t    v;
    dir_row_t row;
    cur_mat = 3'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. The register index is only two bits wide, so an
    // out-of-range row index cannot be driven.
    for (i = 0; i < NumDirRows; i++) begin
      row = DirRows[i];
      if (row.mat != cur_mat) begin
        load_matrix(DirMats[row.mat]);
        cur_mat = row.mat;
      end
      send_vector({row.w, row.z, row.y, row.x}, row.typed,
                  '{lanes: {row.ew, row.ez, row.ey, row.ex}, sat: row.esat});
    end

    // Random phases, each with a freshly drawn matrix.
    for (ph = 0; ph < RandPhases; ph++) begin
      load_matrix(pick_matrix());
      for (n = 0; n < PhaseItems; n++) begin
        for (c = 0; c < Lanes; c++)
          v[c] = ($urandom_range(3) == 0) ? DataW'($urandom) : rand_q16(16);
        send_vector(v, 1'b0, '0);
      end
    end

    if (in_valid_i) in_valid_i <= 1'b0;
    wait_drained();
    repeat (PipeLatency + 4) @(posedge clk_i);
    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
